/* design/dau_pkg.sv */
// Shared widths and constants for the diamond angle to unit vector block.
package dau_pkg;

    localparam int ANGLE_W     = 24;
    localparam int DIR_W       = 16;
    // radicand is (x*x + y*y) scaled so that it always sits in this width
    localparam int ROOT_IN_W   = 2 * ANGLE_W + 2;
    localparam int ROOT_W      = ANGLE_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int DIR_MAX     = 32767;
    localparam int DIR_MIN_MAG = 32768;

endpackage

/* design/dau_front.sv */
// Front stage: wraps the angle into one turn and forms the diamond direction.
module dau_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [dau_pkg::ANGLE_W-1:0] diamond_angle,
    input  logic                               q_full,
    output logic                               q_push,
    output logic [2*(FRAC_BITS+2)-1:0]         q_data
);
    import dau_pkg::*;

    localparam int DW = FRAC_BITS + 2;
    localparam int MW = FRAC_BITS + 1;
    localparam int OW = 2 * (MW + 1);

    localparam logic signed [DW:0] ONE_S   = (DW+1)'(1 << FRAC_BITS);
    localparam logic signed [DW:0] TWO_S   = (DW+1)'(2 << FRAC_BITS);
    localparam logic signed [DW:0] THREE_S = (DW+1)'(3 << FRAC_BITS);
    // 4.0 wraps to the sign bit here; the subtraction still comes out right
    localparam logic signed [DW:0] FOUR_S  = (DW+1)'(4 << FRAC_BITS);

    logic signed [ANGLE_W+DW-1:0] ang_ext;
    logic signed [DW:0]           dv;
    logic signed [DW:0]           x_val;
    logic signed [DW:0]           y_val;
    logic signed [DW:0]           x_abs;
    logic signed [DW:0]           y_abs;
    logic [OW-1:0]                data_next;
    logic [OW-1:0]                data_reg;
    logic                         vld_reg;
    logic                         adv;

    assign ang_ext = (ANGLE_W+DW)'(diamond_angle);
    assign dv      = signed'({1'b0, ang_ext[DW-1:0]});

    always_comb
    begin
        if (dv < TWO_S)
        begin
            x_val = ONE_S - dv;
        end
        else
        begin
            x_val = dv - THREE_S;
        end

        if (dv < THREE_S)
        begin
            if (dv > ONE_S)
            begin
                y_val = TWO_S - dv;
            end
            else
            begin
                y_val = dv;
            end
        end
        else
        begin
            y_val = dv - FOUR_S;
        end

        x_abs = x_val[DW] ? -x_val : x_val;
        y_abs = y_val[DW] ? -y_val : y_val;
    end

    assign data_next = {x_val[DW], x_abs[MW-1:0], y_val[DW], y_abs[MW-1:0]};

    assign adv    = !vld_reg || !q_full;
    assign full   = !adv;
    assign q_push = vld_reg && !q_full;
    assign q_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && push)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* design/dau_fifo.sv */
// Short queue that decouples the front stage from the normalizing back end.
module dau_fifo #(
    parameter int WIDTH = 36
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    import dau_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* design/dau_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
module dau_isqrt #(
    parameter int SIDE_W = 36
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [dau_pkg::ROOT_IN_W-1:0]   radicand,
    input  logic [SIDE_W-1:0]               side_in,
    output logic [dau_pkg::ROOT_W-1:0]      root,
    output logic [SIDE_W-1:0]               side_out
);
    import dau_pkg::*;

    logic [ROOT_IN_W-1:0] rem_next  [ROOT_W-1];
    logic [ROOT_IN_W-1:0] rem_reg   [ROOT_W-1];
    logic [ROOT_W-1:0]    root_next [ROOT_W];
    logic [ROOT_W-1:0]    root_reg  [ROOT_W];
    logic [SIDE_W-1:0]    side_reg  [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        localparam int K = ROOT_W - 1 - i;

        logic [ROOT_IN_W-1:0] rem_in;
        logic [ROOT_IN_W-1:0] trial;
        logic [ROOT_W-1:0]    root_in;
        logic                 take;

        if (i == 0)
        begin : g_first
            assign rem_in  = radicand;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
        end

        // (r + 2^k)^2 - r^2, with r holding only bits above k
        assign trial = (ROOT_IN_W'(root_in) << (K + 1)) | (ROOT_IN_W'(1) << (2 * K));
        assign take  = (rem_in >= trial);
        assign root_next[i] = take ? (root_in | (ROOT_W'(1) << K)) : root_in;

        if (i < ROOT_W - 1)
        begin : g_rem
            assign rem_next[i] = take ? (rem_in - trial) : rem_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ROOT_W - 1; i++)
            begin
                rem_reg[i] <= rem_next[i];
            end
            for (int i = 0; i < ROOT_W; i++)
            begin
                root_reg[i] <= root_next[i];
            end
            side_reg[0] <= side_in;
            for (int i = 1; i < ROOT_W; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign root     = root_reg[ROOT_W-1];
    assign side_out = side_reg[ROOT_W-1];

endmodule

/* design/dau_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module dau_div #(
    parameter int NUM_W = 42,
    parameter int DEN_W = 26,
    parameter int QUO_W = 17,
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag_in,
    output logic [QUO_W-1:0] quo,
    output logic [TAG_W-1:0] tag_out
);

    logic [NUM_W-1:0] rem_next [QUO_W-1];
    logic [NUM_W-1:0] rem_reg  [QUO_W-1];
    logic [DEN_W-1:0] den_reg  [QUO_W-1];
    logic [QUO_W-1:0] quo_next [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    logic [TAG_W-1:0] tag_reg  [QUO_W];

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_stage
        localparam int J = QUO_W - 1 - i;

        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [NUM_W-1:0] dsh;
        logic             take;

        if (i == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        assign dsh  = NUM_W'(den_in) << J;
        assign take = (rem_in >= dsh);
        assign quo_next[i] = take ? (quo_in | (QUO_W'(1) << J)) : quo_in;

        if (i < QUO_W - 1)
        begin : g_rem
            assign rem_next[i] = take ? (rem_in - dsh) : rem_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QUO_W - 1; i++)
            begin
                rem_reg[i] <= rem_next[i];
            end
            den_reg[0] <= den;
            for (int i = 1; i < QUO_W - 1; i++)
            begin
                den_reg[i] <= den_reg[i-1];
            end
            for (int i = 0; i < QUO_W; i++)
            begin
                quo_reg[i] <= quo_next[i];
            end
            tag_reg[0] <= tag_in;
            for (int i = 1; i < QUO_W; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign quo     = quo_reg[QUO_W-1];
    assign tag_out = tag_reg[QUO_W-1];

endmodule

/* design/dau_back.sv */
// Back end: squares, square root, per-component rounded division, saturation.
module dau_back #(
    parameter int FRAC_BITS     = 16,
    parameter int OUT_FRAC_BITS = 15
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  logic [2*(FRAC_BITS+2)-1:0]       q_data,
    output logic                             q_pop,
    input  logic                             pop,
    output logic                             empty,
    output logic signed [dau_pkg::DIR_W-1:0] dir_x,
    output logic signed [dau_pkg::DIR_W-1:0] dir_y
);
    import dau_pkg::*;

    localparam int MW     = FRAC_BITS + 1;
    localparam int SIDE_W = 2 * (MW + 1);
    localparam int SQ_W   = 2 * MW;
    localparam int NS     = ANGLE_W - FRAC_BITS;
    localparam int QW     = OUT_FRAC_BITS + 2;
    localparam int DEN_W  = ROOT_W + 1;
    localparam int NUM_W  = OUT_FRAC_BITS + ANGLE_W + 3;
    localparam int LAT    = ROOT_W + QW + 4;

    localparam int HI_MAG = (OUT_FRAC_BITS >= 15) ? DIR_MAX : (1 << OUT_FRAC_BITS) - 1;
    localparam int LO_MAG = (OUT_FRAC_BITS >= 15) ? DIR_MIN_MAG : (1 << OUT_FRAC_BITS);
    localparam logic [QW-1:0] HI_Q = QW'(HI_MAG);
    localparam logic [QW-1:0] LO_Q = QW'(LO_MAG);

    function automatic logic [DIR_W-1:0] sat_dir(input logic neg, input logic [QW-1:0] q);
        logic [DIR_W:0] m;
        if (neg)
        begin
            m = (q > LO_Q) ? (DIR_W+1)'(LO_MAG) : (DIR_W+1)'(q);
            m = ~m + 1'b1;
        end
        else
        begin
            m = (q > HI_Q) ? (DIR_W+1)'(HI_MAG) : (DIR_W+1)'(q);
        end
        return m[DIR_W-1:0];
    endfunction

    logic [LAT-1:0]       vld_reg;
    logic                 adv;

    logic [MW-1:0]        q_mx;
    logic [MW-1:0]        q_my;
    logic [SQ_W-1:0]      sq_x_reg;
    logic [SQ_W-1:0]      sq_y_reg;
    logic [SIDE_W-1:0]    side0_reg;
    logic [ROOT_IN_W-1:0] rad_next;
    logic [ROOT_IN_W-1:0] rad_reg;
    logic [SIDE_W-1:0]    side1_reg;

    logic [ROOT_W-1:0]    root;
    logic [SIDE_W-1:0]    side2;
    logic [MW-1:0]        mx2;
    logic [MW-1:0]        my2;
    logic [NUM_W-1:0]     num_x_next;
    logic [NUM_W-1:0]     num_y_next;
    logic [NUM_W-1:0]     num_x_reg;
    logic [NUM_W-1:0]     num_y_reg;
    logic [DEN_W-1:0]     den_reg;
    logic                 sx_reg;
    logic                 sy_reg;

    logic [QW-1:0]        quo_x;
    logic [QW-1:0]        quo_y;
    logic                 sx_out;
    logic                 sy_out;
    logic [DIR_W-1:0]     dir_x_reg;
    logic [DIR_W-1:0]     dir_y_reg;

    // whole back end moves together; it holds only while a result waits
    assign adv   = !vld_reg[LAT-1] || pop;
    assign q_pop = adv && !q_empty;
    assign empty = !vld_reg[LAT-1];

    assign q_mx = q_data[SIDE_W-2 -: MW];
    assign q_my = q_data[MW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], !q_empty};
        end
    end

    assign rad_next = ROOT_IN_W'({1'b0, sq_x_reg} + {1'b0, sq_y_reg}) << (2 * NS);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_x_reg  <= q_mx * q_mx;
            sq_y_reg  <= q_my * q_my;
            side0_reg <= q_data;
            rad_reg   <= rad_next;
            side1_reg <= side0_reg;
        end
    end

    dau_isqrt #(
        .SIDE_W   (SIDE_W)
    ) u_isqrt (
        .clk      (clk),
        .en       (adv),
        .radicand (rad_reg),
        .side_in  (side1_reg),
        .root     (root),
        .side_out (side2)
    );

    assign mx2 = side2[SIDE_W-2 -: MW];
    assign my2 = side2[MW-1:0];

    // round to nearest: (2*mag*2^k + n) / (2n)
    assign num_x_next = (NUM_W'(mx2) << (OUT_FRAC_BITS + NS + 1)) + NUM_W'(root);
    assign num_y_next = (NUM_W'(my2) << (OUT_FRAC_BITS + NS + 1)) + NUM_W'(root);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_x_reg <= num_x_next;
            num_y_reg <= num_y_next;
            den_reg   <= {root, 1'b0};
            sx_reg    <= side2[SIDE_W-1];
            sy_reg    <= side2[MW];
        end
    end

    dau_div #(
        .NUM_W   (NUM_W),
        .DEN_W   (DEN_W),
        .QUO_W   (QW),
        .TAG_W   (1)
    ) u_div_x (
        .clk     (clk),
        .en      (adv),
        .num     (num_x_reg),
        .den     (den_reg),
        .tag_in  (sx_reg),
        .quo     (quo_x),
        .tag_out (sx_out)
    );

    dau_div #(
        .NUM_W   (NUM_W),
        .DEN_W   (DEN_W),
        .QUO_W   (QW),
        .TAG_W   (1)
    ) u_div_y (
        .clk     (clk),
        .en      (adv),
        .num     (num_y_reg),
        .den     (den_reg),
        .tag_in  (sy_reg),
        .quo     (quo_y),
        .tag_out (sy_out)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dir_x_reg <= sat_dir(sx_out, quo_x);
            dir_y_reg <= sat_dir(sy_out, quo_y);
        end
    end

    assign dir_x = signed'(dir_x_reg);
    assign dir_y = signed'(dir_y_reg);

endmodule

/* design/diamond_angle_to_unit_vector.sv */
// Diamond angle to unit direction vector: top level.
// Path of a beat: front register, queue, squares and radicand registers, the 25-stage
// square root, numerator registers, OUT_FRAC_BITS + 2 stage dividers and output register.
// Throughput: one beat per cycle unless stalled; a 4-entry queue links front to back end.
// Reset clears only valid flags and queue pointers; there is no clearing pass.
module diamond_angle_to_unit_vector #(
    parameter int FRAC_BITS     = 16,
    parameter int OUT_FRAC_BITS = 15
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [dau_pkg::ANGLE_W-1:0] diamond_angle,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [dau_pkg::DIR_W-1:0]   dir_x,
    output logic signed [dau_pkg::DIR_W-1:0]   dir_y
);
    import dau_pkg::*;

    localparam int QW_DATA = 2 * (FRAC_BITS + 2);

    logic               fq_push;
    logic [QW_DATA-1:0] fq_wdata;
    logic               fq_full;
    logic               fq_pop;
    logic [QW_DATA-1:0] fq_rdata;
    logic               fq_empty;

    dau_front #(
        .FRAC_BITS     (FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .diamond_angle (diamond_angle),
        .q_full        (fq_full),
        .q_push        (fq_push),
        .q_data        (fq_wdata)
    );

    dau_fifo #(
        .WIDTH   (QW_DATA)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_data (fq_wdata),
        .full    (fq_full),
        .rd_en   (fq_pop),
        .rd_data (fq_rdata),
        .empty   (fq_empty)
    );

    dau_back #(
        .FRAC_BITS     (FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (fq_empty),
        .q_data        (fq_rdata),
        .q_pop         (fq_pop),
        .pop           (pop),
        .empty         (empty),
        .dir_x         (dir_x),
        .dir_y         (dir_y)
    );

endmodule
